[src/bitmap_page_allocator_defines.svh]
// Assertion macros for the bitmap page allocator.
// Used by the top level only; no other dependencies.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/bpa_pkg.sv]
// Shared types and constants for the bitmap page allocator.
// No dependencies.
`timescale 1ns / 1ps
package bpa_pkg;
    localparam int POOL_PAGES_DEF = 1024;
    localparam int CNT_W  = 11;
    localparam int PAGE_W = 10;
    localparam int ST_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam logic [CNT_W-1:0] SIZE_RST = 11'd1024;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;
    localparam logic [1:0] POL_BUDDY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KSIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USIZE  = 2'd2;

    typedef enum logic [3:0] {
        C_NOP, C_CLR, C_LOAD, C_RES_NOFIT, C_RES_BAD, C_SCAN,
        C_READ, C_EVAL, C_END, C_WRITE, C_SEND
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic bad_range;
        logic at_limit;
        logic hit;
        logic miss;
        logic end_write;
        logic end_retry;
        logic wr_last;
        logic clr_last;
        logic out_busy;
    } t_dp_st;
endpackage

[src/bitmap_page_allocator.sv]
// Top level of the bitmap page allocator: sequencer plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp and bitmap_page_allocator_defines.svh.
//
//  port group   dir  contents
//  s_axis       in   tuser {pool_select, mode}; tdata {first_page, page_count}
//  m_axis       out  tdata {pages_taken, granted_page, status}
//  i_cfg_*      in   index 0 fit_policy, 1 kernel_pool_size, 2 user_pool_size
//
// After reset both bitmaps are cleared one page a cycle, with s_axis_tready
// low. A request scans one page per read-and-evaluate step, then marks or
// clears one page per write step; the single-port bitmap read and the
// one-page-per-step scan set this pace. A next-fit wrap can scan twice.
// One request is in flight at a time; a finished result waits in the output
// register while m_axis_tready is low, and the next request is taken then.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_defines.svh"
module bitmap_page_allocator #(
    parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [10:0] page_count, [20:11] first_page, rest zero
    input  logic [bpa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] mode, [1] pool_select
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [11:2] granted_page, [22:12] pages_taken, rest zero
    output logic [bpa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    bpa_pkg::t_cmd   cmd;
    bpa_pkg::t_dp_st st;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_st       (st),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    bpa_dp #(.POOL_PAGES(POOL_PAGES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    logic                     in_beat;
    logic                     out_fail;
    logic [bpa_pkg::ST_W-1:0] out_status;

    assign in_beat    = s_axis_tvalid && s_axis_tready;
    assign out_status = m_axis_tdata[bpa_pkg::ST_W-1:0];
    assign out_fail   = m_axis_tvalid && (out_status != bpa_pkg::ST_OK);

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_beat, !s_axis_tready)
    `ASSERT_SAME(a_fail_no_pages, i_clk, i_rst_n, out_fail, m_axis_tdata[22:2] == '0)
    `ASSERT_SAME(a_status_range, i_clk, i_rst_n, m_axis_tvalid, out_status <= bpa_pkg::ST_BAD)
endmodule

[src/bpa_ctrl.sv]
// Request sequencer for the bitmap page allocator.
// Depends on bpa_pkg for the command and status types.
`timescale 1ns / 1ps
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  bpa_pkg::t_dp_st i_st,
    output logic           o_in_ready,
    output bpa_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_CHK, S_RD, S_EV, S_END, S_WR, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = bpa_pkg::C_NOP;
        case (r_state)
            S_CLR: begin
                o_cmd = bpa_pkg::C_CLR;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = bpa_pkg::C_LOAD;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_st.zero) begin
                    o_cmd   = bpa_pkg::C_RES_NOFIT;
                    n_state = S_OUT;
                end else if (i_st.bad_range) begin
                    o_cmd   = bpa_pkg::C_RES_BAD;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = bpa_pkg::C_SCAN;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_st.at_limit) begin
                    n_state = S_END;
                end else begin
                    o_cmd   = bpa_pkg::C_READ;
                    n_state = S_EV;
                end
            end
            S_EV: begin
                o_cmd = bpa_pkg::C_EVAL;
                if (i_st.hit)       n_state = S_WR;
                else if (i_st.miss) n_state = S_OUT;
                else                n_state = S_RD;
            end
            S_END: begin
                o_cmd = bpa_pkg::C_END;
                if (i_st.end_write)      n_state = S_WR;
                else if (i_st.end_retry) n_state = S_RD;
                else                     n_state = S_OUT;
            end
            S_WR: begin
                o_cmd = bpa_pkg::C_WRITE;
                if (i_st.wr_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_st.out_busy) begin
                    o_cmd   = bpa_pkg::C_SEND;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end
endmodule

[src/bpa_dp.sv]
// Datapath for the bitmap page allocator: page bitmaps, scan counters,
// config registers and the result register. Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_dp #(
    parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bpa_pkg::t_cmd                     i_cmd,
    output bpa_pkg::t_dp_st                   o_st,
    input  logic                              i_cfg_wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                        i_in_user,
    input  logic [bpa_pkg::IN_DATA_W-1:0]     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bpa_pkg::OUT_DATA_W-1:0]    o_out_data
);
    localparam int AW = $clog2(POOL_PAGES);
    localparam int CW = (AW + 2 > 12) ? AW + 2 : 12;
    localparam int CN = bpa_pkg::CNT_W;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam int OW = bpa_pkg::OUT_DATA_W;

    logic mem [2*POOL_PAGES];
    logic r_rdata;

    logic [1:0]    r_policy;
    logic [CN-1:0] r_ksize, r_usize;
    logic [AW-1:0] r_kpos, r_upos;
    logic [AW:0]   r_clr;
    logic          r_mode, r_pool, r_second, r_have, r_wval;
    logic [CN-1:0] r_cnt;
    logic [PW-1:0] r_startp;
    logic [CW-1:0] r_n, r_size, r_i, r_lim, r_run, r_hstart, r_hlen, r_blen, r_at;
    logic [bpa_pkg::ST_W-1:0] r_res_st;
    logic          r_ovalid;
    logic [bpa_pkg::OUT_DATA_W-1:0] r_odata;

    // request decode
    logic          in_mode, in_pool;
    logic [CN-1:0] in_cnt, cm1;
    logic [PW-1:0] in_startp;
    logic [CN:0]   p2;
    logic [CW-1:0] in_n, in_size, in_sz_ext;
    logic [AW-1:0] cur_pos;

    assign in_mode   = i_in_user[0];
    assign in_pool   = i_in_user[1];
    assign in_cnt    = i_in_data[CN-1:0];
    assign in_startp = i_in_data[CN+PW-1:CN];
    assign cm1       = in_cnt - CN'(1);

    always_comb begin
        p2 = (CN+1)'(1);
        for (int k = 0; k < CN; k++) begin
            if (cm1[k]) p2 = (CN+1)'(2) << k;
        end
    end

    assign in_n      = (r_policy == bpa_pkg::POL_BUDDY) ? CW'(p2) : CW'(in_cnt);
    assign in_sz_ext = CW'(in_pool ? r_usize : r_ksize);
    assign in_size   = (in_sz_ext > CW'(POOL_PAGES)) ? CW'(POOL_PAGES) : in_sz_ext;
    assign cur_pos   = r_pool ? r_upos : r_kpos;

    // per-page evaluation
    logic          bit_used, run_hit, h_close, better;
    logic [CW-1:0] run_base, run_new, run_at, len_c, start_c, lim_at;
    logic [CW-1:0] i_nx, end_at;

    assign bit_used = r_rdata;
    assign i_nx     = r_i + CW'(1);
    assign run_base = (r_policy == bpa_pkg::POL_BUDDY && (r_i & (r_n - CW'(1))) == '0)
                      ? '0 : r_run;
    assign run_new  = bit_used ? '0 : run_base + CW'(1);
    assign run_hit  = !bit_used && (run_base + CW'(1) == r_n);
    assign run_at   = i_nx - r_n;
    assign h_close  = (bit_used && r_hlen != '0) || (!bit_used && i_nx == r_lim);
    assign len_c    = bit_used ? r_hlen : r_hlen + CW'(1);
    assign start_c  = (r_hlen == '0) ? r_i : r_hstart;
    assign better   = h_close && len_c >= r_n && (!r_have || len_c < r_blen);
    assign lim_at   = run_at + r_n;
    assign end_at   = r_at + r_n;

    logic is_best;
    assign is_best = (r_policy == bpa_pkg::POL_BEST);

    always_comb begin
        o_st.zero      = (r_cnt == '0);
        o_st.bad_range = r_mode && (CW'(r_startp) + r_n > r_size);
        o_st.at_limit  = (r_i >= r_lim);
        o_st.miss      = r_mode && !bit_used;
        o_st.hit       = !r_mode && (is_best ? (better && len_c == r_n) : run_hit);
        o_st.end_write = r_mode || (is_best && r_have);
        o_st.end_retry = !r_mode && r_policy == bpa_pkg::POL_NEXT && !r_second
                         && cur_pos != '0;
        o_st.wr_last   = (i_nx == r_lim);
        o_st.clr_last  = &r_clr;
        o_st.out_busy  = r_ovalid && !i_out_ready;
    end

    // bitmap store, one page per access
    always_ff @(posedge i_clk) begin
        if (i_cmd == bpa_pkg::C_CLR) mem[r_clr] <= 1'b0;
        else if (i_cmd == bpa_pkg::C_WRITE) mem[{r_pool, r_i[AW-1:0]}] <= r_wval;
        if (i_cmd == bpa_pkg::C_READ) r_rdata <= mem[{r_pool, r_i[AW-1:0]}];
    end

    // control and config state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= bpa_pkg::POL_FIRST;
            r_ksize  <= bpa_pkg::SIZE_RST;
            r_usize  <= bpa_pkg::SIZE_RST;
            r_kpos   <= '0;
            r_upos   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd == bpa_pkg::C_CLR) r_clr <= r_clr + (AW+1)'(1);
            if (i_cmd == bpa_pkg::C_SEND) r_ovalid <= 1'b1;
            else if (i_out_ready)         r_ovalid <= 1'b0;
            if (i_cmd == bpa_pkg::C_WRITE && o_st.wr_last && !r_mode
                && r_policy == bpa_pkg::POL_NEXT) begin
                if (r_pool) r_upos <= (end_at == r_size) ? '0 : AW'(end_at);
                else        r_kpos <= (end_at == r_size) ? '0 : AW'(end_at);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    bpa_pkg::CFG_POLICY: begin
                        r_policy <= i_cfg_data[1:0];
                        r_kpos   <= '0;
                        r_upos   <= '0;
                    end
                    bpa_pkg::CFG_KSIZE: r_ksize <= i_cfg_data;
                    bpa_pkg::CFG_USIZE: r_usize <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // scan state and result
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            bpa_pkg::C_LOAD: begin
                r_mode   <= in_mode;
                r_pool   <= in_pool;
                r_cnt    <= in_cnt;
                r_startp <= in_startp;
                r_n      <= in_n;
                r_size   <= in_size;
            end
            bpa_pkg::C_RES_NOFIT: r_res_st <= bpa_pkg::ST_NOFIT;
            bpa_pkg::C_RES_BAD:   r_res_st <= bpa_pkg::ST_BAD;
            bpa_pkg::C_SCAN: begin
                r_run    <= '0;
                r_hlen   <= '0;
                r_have   <= 1'b0;
                r_second <= 1'b0;
                if (r_mode) begin
                    r_i   <= CW'(r_startp);
                    r_lim <= CW'(r_startp) + r_n;
                end else begin
                    r_i   <= (r_policy == bpa_pkg::POL_NEXT) ? CW'(cur_pos) : '0;
                    r_lim <= r_size;
                end
            end
            bpa_pkg::C_EVAL: begin
                r_run  <= run_new;
                r_hlen <= bit_used ? '0 : r_hlen + CW'(1);
                if (!bit_used && r_hlen == '0) r_hstart <= r_i;
                if (is_best && better) begin
                    r_have <= 1'b1;
                    r_blen <= len_c;
                    r_at   <= start_c;
                end
                if (o_st.miss) r_res_st <= bpa_pkg::ST_BAD;
                if (o_st.hit) begin
                    r_wval <= 1'b1;
                    if (is_best) begin
                        r_i   <= start_c;
                        r_lim <= start_c + r_n;
                    end else begin
                        r_at  <= run_at;
                        r_i   <= run_at;
                        r_lim <= lim_at;
                    end
                end else begin
                    r_i <= i_nx;
                end
            end
            bpa_pkg::C_END: begin
                if (r_mode) begin
                    r_i    <= CW'(r_startp);
                    r_wval <= 1'b0;
                end else if (is_best && r_have) begin
                    r_i    <= r_at;
                    r_lim  <= end_at;
                    r_wval <= 1'b1;
                end else if (o_st.end_retry) begin
                    r_i      <= '0;
                    r_run    <= '0;
                    r_second <= 1'b1;
                end else begin
                    r_res_st <= bpa_pkg::ST_NOFIT;
                end
            end
            bpa_pkg::C_WRITE: begin
                r_i <= i_nx;
                if (o_st.wr_last) r_res_st <= bpa_pkg::ST_OK;
            end
            bpa_pkg::C_SEND: begin
                // failed requests carry only the status
                if (r_res_st == bpa_pkg::ST_OK) begin
                    r_odata <= OW'({r_n[CN-1:0],
                                    (r_mode ? {PW{1'b0}} : r_at[PW-1:0]),
                                    r_res_st});
                end else begin
                    r_odata <= OW'(r_res_st);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
endmodule
